>>> hdl/des_round_function_macros.svh
// ----------------------------------------------------------------------------
// des_round_function_macros.svh
// Assertion macros shared by the DES round function RTL.
// ----------------------------------------------------------------------------
`ifndef DES_ROUND_FUNCTION_MACROS_SVH
`define DES_ROUND_FUNCTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DRF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/des_rf_pkg.sv
// ----------------------------------------------------------------------------
// des_rf_pkg
// Tables and bit-wiring functions for the DES Feistel round function.
// ----------------------------------------------------------------------------
package des_rf_pkg;

   localparam int unsigned HALF_W  = 32;
   localparam int unsigned WIDE_W  = 48;
   localparam int unsigned NUM_BOX = 8;

   typedef logic [HALF_W-1:0] half_type;
   typedef logic [WIDE_W-1:0] wide_type;

   // S1..S8, each indexed by {row, column} = {b5, b0, b4..b1}
   localparam logic [3:0] SBOX [NUM_BOX][64] = '{
      '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
        4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
        4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
        4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
        4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
        4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
        4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
      '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
        4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
        4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
        4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
        4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
        4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
        4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
        4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
      '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
        4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
        4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
        4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
        4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
        4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
        4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
        4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
      '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
        4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
        4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
        4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
        4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
        4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
        4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
        4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
      '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
        4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
        4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
        4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
        4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
        4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
        4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
        4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
      '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
        4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
        4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
        4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
        4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
        4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
        4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
        4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
      '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
        4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
        4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
        4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
        4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
        4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
        4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
        4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
      '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
        4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
        4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
        4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
        4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
        4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
        4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
        4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
   };

   // E expansion: each 6-bit group takes four bits plus a neighbour either side
   function automatic wide_type expand(half_type x);
      return {x[0], x[31:27], x[28:23], x[24:19], x[20:15],
              x[16:11], x[12:7], x[8:3], x[4:0], x[31]};
   endfunction

   // P permutation, bit 1 of the standard numbering is the MSB here
   function automatic half_type permute(half_type y);
      return {y[16], y[25], y[12], y[11], y[3],  y[20], y[4],  y[15],
              y[31], y[17], y[9],  y[6],  y[27], y[14], y[1],  y[22],
              y[30], y[24], y[8],  y[18], y[0],  y[5],  y[29], y[23],
              y[13], y[19], y[2],  y[26], y[10], y[21], y[28], y[7]};
   endfunction

   // Row from the outer bits, column from the middle four
   function automatic logic [5:0] sbox_addr(logic [5:0] grp);
      return {grp[5], grp[0], grp[4:1]};
   endfunction

endpackage

>>> hdl/des_round_function.sv
// ----------------------------------------------------------------------------
// des_round_function
// DES Feistel f function: expansion, key mix, S-boxes and P, three stages.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle while the result side is not stalled, and
// returns one beat per accepted beat, in order. The work is split over the
// three register stages: E expansion with the key XOR, the eight parallel
// S-box lookups, and the P permutation into the output register. Each stage
// holds its own valid bit and advances whenever it is empty or its content
// moves on, so a stall at rsp_ready backs up the pipe one stage at a time and
// nothing is dropped or repeated. There are no configuration registers and
// no state beyond the pipeline; reset only empties the stages.
// ----------------------------------------------------------------------------
`include "des_round_function_macros.svh"

module des_round_function
   import des_rf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [31:0]  req_half_block,
   input  logic [47:0]  req_round_subkey,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [31:0]  rsp_f_value
);

   // Stage 1: expanded half mixed with the subkey
   logic     s1_valid_ff, s1_valid_in;
   wide_type s1_mix_ff, s1_mix_in;
   // Stage 2: joined S-box outputs, first box in the top nibble
   logic     s2_valid_ff, s2_valid_in;
   half_type s2_sout_ff, s2_sout_in;
   // Stage 3: output register
   logic     rsp_valid_ff, rsp_valid_in;
   half_type rsp_f_value_ff, rsp_f_value_in;

   logic     out_adv;
   logic     s2_adv;
   logic     s1_adv;
   half_type sbox_out;

   // A stage may load when it is empty or its beat leaves this cycle
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || out_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;

   // Eight independent lookups, one per 6-bit group, MSB group into S1
   for (genvar k = 0; k < NUM_BOX; k++) begin : g_box
      localparam int unsigned HI = WIDE_W - 1 - 6 * k;
      assign sbox_out[HALF_W-1-4*k -: 4] = SBOX[k][sbox_addr(s1_mix_ff[HI -: 6])];
   end

   always_comb begin
      // hold by default
      s1_valid_in    = s1_valid_ff;
      s1_mix_in      = s1_mix_ff;
      s2_valid_in    = s2_valid_ff;
      s2_sout_in     = s2_sout_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_f_value_in = rsp_f_value_ff;

      if (s1_adv) begin
         s1_valid_in = req_valid;
         s1_mix_in   = expand(req_half_block) ^ req_round_subkey;
      end
      if (s2_adv) begin
         s2_valid_in = s1_valid_ff;
         s2_sout_in  = sbox_out;
      end
      if (out_adv) begin
         rsp_valid_in   = s2_valid_ff;
         rsp_f_value_in = permute(s2_sout_ff);
      end
   end

   // Valid bits: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      s1_mix_ff      <= s1_mix_in;
      s2_sout_ff     <= s2_sout_in;
      rsp_f_value_ff <= rsp_f_value_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_f_value = rsp_f_value_ff;

   // An accepted beat lands in stage 1
   `DRF_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && req_ready, s1_valid_ff, "accepted beat lost at stage 1")
   // A blocked stage 1 beat holds its data
   `DRF_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s2_adv, s1_valid_ff && $stable(s1_mix_ff), "stage 1 beat changed while blocked")
   // A blocked stage 2 beat holds its data
   `DRF_ASSERT_NEXT(a_s2_hold, clock, reset, s2_valid_ff && !out_adv, s2_valid_ff && $stable(s2_sout_ff), "stage 2 beat changed while blocked")
   // A full, stalled pipe takes no new beat
   `DRF_ASSERT_NOW(a_full_stall, clock, reset, s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready, "beat accepted into a full pipe")

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DES round function pipeline.
// ----------------------------------------------------------------------------
// Drives (half block, round subkey) beats into the block and predicts each
// f value from the E, S-box and P tables of the standard. A scoreboard keeps
// the predicted values in order and compares every response beat with the
// oldest one. A directed set comes first, then random beats. Both sides idle
// at random, with quiet stretches, and the response side holds off for a long
// stretch so that the pipeline fills and back-pressures the request side.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_BEATS = 800;
   localparam int unsigned CYCLE_LIMIT  = 100000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned IDLE_PCT     = 21;

   // E expansion: source bit of each of the 48 output bits, 1 = MSB
   localparam byte unsigned E_SEL [48] = '{
      32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9,
      8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
      16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
      24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1};

   // P permutation: source bit of each of the 32 output bits, 1 = MSB
   localparam byte unsigned P_SEL [32] = '{
      16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
      2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25};

   // S1..S8, indexed by row * 16 + column
   localparam logic [3:0] S_BOX [8][64] = '{
      '{14, 4, 13, 1, 2, 15, 11, 8, 3, 10, 6, 12, 5, 9, 0, 7,
        0, 15, 7, 4, 14, 2, 13, 1, 10, 6, 12, 11, 9, 5, 3, 8,
        4, 1, 14, 8, 13, 6, 2, 11, 15, 12, 9, 7, 3, 10, 5, 0,
        15, 12, 8, 2, 4, 9, 1, 7, 5, 11, 3, 14, 10, 0, 6, 13},
      '{15, 1, 8, 14, 6, 11, 3, 4, 9, 7, 2, 13, 12, 0, 5, 10,
        3, 13, 4, 7, 15, 2, 8, 14, 12, 0, 1, 10, 6, 9, 11, 5,
        0, 14, 7, 11, 10, 4, 13, 1, 5, 8, 12, 6, 9, 3, 2, 15,
        13, 8, 10, 1, 3, 15, 4, 2, 11, 6, 7, 12, 0, 5, 14, 9},
      '{10, 0, 9, 14, 6, 3, 15, 5, 1, 13, 12, 7, 11, 4, 2, 8,
        13, 7, 0, 9, 3, 4, 6, 10, 2, 8, 5, 14, 12, 11, 15, 1,
        13, 6, 4, 9, 8, 15, 3, 0, 11, 1, 2, 12, 5, 10, 14, 7,
        1, 10, 13, 0, 6, 9, 8, 7, 4, 15, 14, 3, 11, 5, 2, 12},
      '{7, 13, 14, 3, 0, 6, 9, 10, 1, 2, 8, 5, 11, 12, 4, 15,
        13, 8, 11, 5, 6, 15, 0, 3, 4, 7, 2, 12, 1, 10, 14, 9,
        10, 6, 9, 0, 12, 11, 7, 13, 15, 1, 3, 14, 5, 2, 8, 4,
        3, 15, 0, 6, 10, 1, 13, 8, 9, 4, 5, 11, 12, 7, 2, 14},
      '{2, 12, 4, 1, 7, 10, 11, 6, 8, 5, 3, 15, 13, 0, 14, 9,
        14, 11, 2, 12, 4, 7, 13, 1, 5, 0, 15, 10, 3, 9, 8, 6,
        4, 2, 1, 11, 10, 13, 7, 8, 15, 9, 12, 5, 6, 3, 0, 14,
        11, 8, 12, 7, 1, 14, 2, 13, 6, 15, 0, 9, 10, 4, 5, 3},
      '{12, 1, 10, 15, 9, 2, 6, 8, 0, 13, 3, 4, 14, 7, 5, 11,
        10, 15, 4, 2, 7, 12, 9, 5, 6, 1, 13, 14, 0, 11, 3, 8,
        9, 14, 15, 5, 2, 8, 12, 3, 7, 0, 4, 10, 1, 13, 11, 6,
        4, 3, 2, 12, 9, 5, 15, 10, 11, 14, 1, 7, 6, 0, 8, 13},
      '{4, 11, 2, 14, 15, 0, 8, 13, 3, 12, 9, 7, 5, 10, 6, 1,
        13, 0, 11, 7, 4, 9, 1, 10, 14, 3, 5, 12, 2, 15, 8, 6,
        1, 4, 11, 13, 12, 3, 7, 14, 10, 15, 6, 8, 0, 5, 9, 2,
        6, 11, 13, 8, 1, 4, 10, 7, 9, 5, 0, 15, 14, 2, 3, 12},
      '{13, 2, 8, 4, 6, 15, 11, 1, 10, 9, 3, 14, 5, 0, 12, 7,
        1, 15, 13, 8, 10, 3, 7, 4, 12, 5, 6, 11, 0, 14, 9, 2,
        7, 11, 4, 1, 9, 12, 14, 2, 0, 6, 10, 13, 15, 3, 5, 8,
        2, 1, 14, 7, 4, 10, 8, 13, 15, 12, 9, 0, 3, 5, 6, 11}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_half_block = '0;
   logic [47:0] req_round_subkey = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_f_value;

   bit          sender_idles = 1'b1;
   int unsigned cycle_count = 0;

   // Feistel f: expand, mix in the subkey, substitute, permute.
   // Bit n of the standard numbering sits at vector index 32 - n (or 48 - n).
   function automatic logic [31:0] feistel_f(logic [31:0] half, logic [47:0] subkey);
      logic [47:0] mixed;
      logic [31:0] joined;
      logic [31:0] result;
      logic [5:0]  grp;
      for (int i = 0; i < 48; i++)
         mixed[47-i] = half[32-E_SEL[i]];
      mixed = mixed ^ subkey;
      // Group k feeds box k+1: row from the outer bits, column from the middle four
      for (int k = 0; k < 8; k++) begin
         grp = mixed[47-6*k -: 6];
         joined[31-4*k -: 4] = S_BOX[k][{grp[5], grp[0], grp[4:1]}];
      end
      for (int i = 0; i < 32; i++)
         result[31-i] = joined[32-P_SEL[i]];
      return result;
   endfunction

   // In-order store of predicted f values
   class f_value_scoreboard;
      logic [31:0] expected_q[$];
      int unsigned failures = 0;

      function void note_request(logic [31:0] half, logic [47:0] subkey);
         expected_q.push_back(feistel_f(half, subkey));
      endfunction

      function void check_response(logic [31:0] actual);
         logic [31:0] expected;
         if (expected_q.size() == 0) begin
            $error("unexpected response beat: f_value actual %08h", actual);
            failures++;
            return;
         end
         expected = expected_q.pop_front();
         if (actual !== expected) begin
            $error("f_value mismatch: expected %08h actual %08h", expected, actual);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   f_value_scoreboard f_values = new();

   des_round_function uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_half_block   (req_half_block),
      .req_round_subkey (req_round_subkey),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_f_value      (rsp_f_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Sample both channels at the rising edge; inputs only move at the falling
   // edge, so the values seen here are the ones the block sees.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            f_values.note_request(req_half_block, req_round_subkey);
         if (rsp_valid && rsp_ready)
            f_values.check_response(rsp_f_value);
      end
   end

   // Watchdog: end the run if the pipe wedges
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL des_round_function");
         $finish;
      end
   end

   // Offer one request beat and hold it until accepted. Call at a falling edge;
   // returns at the falling edge after acceptance, with valid still high so
   // that a back-to-back beat needs no second assignment in the same step.
   task automatic send_beat(logic [31:0] half, logic [47:0] subkey);
      while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_half_block   <= half;
      req_round_subkey <= subkey;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
   endtask

   // Response side: random stalls, one long hold-off to fill the pipe and
   // back up the request side, and a quiet stretch of constant ready.
   initial begin : response_side
      int unsigned ready_cycle;
      ready_cycle = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         ready_cycle++;
         if (ready_cycle >= 400 && ready_cycle < 560)
            rsp_ready <= 1'b0;
         else if (ready_cycle >= 800 && ready_cycle < 1100)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin : request_side
      logic [31:0] half;
      logic [47:0] subkey;

      // Hold reset, then release it at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, alternating patterns, walking ones at both ends
      send_beat(32'h0000_0000, 48'h0000_0000_0000);
      send_beat(32'hffff_ffff, 48'hffff_ffff_ffff);
      send_beat(32'h0000_0000, 48'hffff_ffff_ffff);
      send_beat(32'hffff_ffff, 48'h0000_0000_0000);
      send_beat(32'haaaa_aaaa, 48'h5555_5555_5555);
      send_beat(32'h5555_5555, 48'haaaa_aaaa_aaaa);
      send_beat(32'haaaa_aaaa, 48'haaaa_aaaa_aaaa);
      send_beat(32'h5555_5555, 48'h5555_5555_5555);
      send_beat(32'h0000_0001, 48'h0000_0000_0000);
      send_beat(32'h8000_0000, 48'h0000_0000_0000);
      send_beat(32'h0000_0000, 48'h0000_0000_0001);
      send_beat(32'h0000_0000, 48'h8000_0000_0000);
      send_beat(32'h0123_4567, 48'h0123_4567_89ab);
      send_beat(32'hfedc_ba98, 48'hfedc_ba98_7654);
      // Every 6-bit group all ones with outer bits only, then middle bits only
      send_beat(32'h0000_0000, 48'h8618_6186_1861);
      send_beat(32'h0000_0000, 48'h79e7_9e79_e79e);

      // Random beats, with a stretch of constant valid in the middle
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         sender_idles = !(n >= 300 && n < 450);
         half   = $urandom;
         subkey = {16'($urandom), 32'($urandom)};
         send_beat(half, subkey);
      end
      req_valid <= 1'b0;

      // Drain, then keep watching for any stray beat to show up
      while (f_values.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (f_values.failures == 0)
         $display("PASS des_round_function");
      else
         $display("FAIL des_round_function");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/des_rf_pkg.sv
hdl/des_round_function.sv
tb/testbench.sv
